@@ rtl/bnrem_pkg.sv @@
// Package for the multi-precision remainder-by-word block.
// Holds default widths, the sequencer state type and the datapath control struct.
// No dependencies.
package bnrem_pkg;

    localparam int DIGIT_BITS_DEF   = 24;
    localparam int DIVISOR_BITS_DEF = 48;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // Commands from the sequencer to the serial reducer.
    typedef struct packed {
        logic load;   // capture digit and divisor
        logic step;   // shift in one digit bit and reduce
        logic clear;  // zero the running remainder
    } core_ctrl_t;

endpackage

@@ rtl/bnrem_core.sv @@
// Bit-serial reducer: shifts one digit bit per step into the running remainder
// and subtracts the divisor once when needed. Depends on bnrem_pkg.
module bnrem_core #(
    parameter int DIGIT_BITS   = bnrem_pkg::DIGIT_BITS_DEF,
    parameter int DIVISOR_BITS = bnrem_pkg::DIVISOR_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bnrem_pkg::core_ctrl_t     ctrl,
    input  logic [DIGIT_BITS-1:0]     digit,
    input  logic [DIVISOR_BITS-1:0]   divisor,
    output logic [DIVISOR_BITS-1:0]   remainder
);

    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [DIGIT_BITS-1:0]   dig_reg;
    logic [DIVISOR_BITS-1:0] div_reg;
    logic [DIVISOR_BITS-1:0] shifted;
    logic [DIVISOR_BITS-1:0] diff;
    logic                    carry;

    // The bit shifted out of the top counts as 2^DIVISOR_BITS, which always
    // exceeds the divisor, so a subtraction is then forced.
    always_comb begin
        carry    = rem_reg[DIVISOR_BITS-1];
        shifted  = {rem_reg[DIVISOR_BITS-2:0], dig_reg[DIGIT_BITS-1]};
        diff     = shifted - div_reg;
        rem_next = (carry || (shifted >= div_reg)) ? diff : shifted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (ctrl.clear) begin
            rem_reg <= '0;
        end else if (ctrl.step) begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            dig_reg <= digit;
            div_reg <= divisor;
        end else if (ctrl.step) begin
            dig_reg <= {dig_reg[DIGIT_BITS-2:0], 1'b0};
        end
    end

    assign remainder = rem_reg;

endmodule

@@ rtl/bignum_remainder_by_word_top.sv @@
// After a digit is accepted, the sequencer steps the serial reducer once per
// digit bit in ST_RUN and then passes through ST_DONE; a digit with a zero
// divisor skips ST_RUN and goes straight to ST_DONE. A new digit is accepted
// only once the sequencer is back in ST_IDLE; a final digit also waits in
// ST_DONE for the output register to be free. Synchronous active-low reset
// clears the running remainder, error flag, sequencer and output valid.
module bignum_remainder_by_word_top #(
    parameter int DIGIT_BITS   = bnrem_pkg::DIGIT_BITS_DEF,
    parameter int DIVISOR_BITS = bnrem_pkg::DIVISOR_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [DIGIT_BITS-1:0]    s_digit,
    input  logic [DIVISOR_BITS-1:0]  s_divisor,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DIVISOR_BITS-1:0]  m_remainder,
    output logic                     m_zero_divisor
);

    localparam int CNT_W = $clog2(DIGIT_BITS);

    bnrem_pkg::state_t       state_reg, state_next;
    bnrem_pkg::core_ctrl_t   ctrl;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    last_reg, last_next;
    logic                    err_reg, err_next;
    logic                    m_valid_reg, m_valid_next;
    logic [DIVISOR_BITS-1:0] m_rem_reg;
    logic                    m_zd_reg;
    logic                    out_load;
    logic                    s_accept;
    logic [DIVISOR_BITS-1:0] core_rem;

    assign s_ready  = (state_reg == bnrem_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        err_next     = err_reg;
        ctrl         = '0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            bnrem_pkg::ST_IDLE: begin
                if (s_accept) begin
                    last_next = s_last;
                    if (s_divisor == '0) begin
                        err_next   = 1'b1;
                        state_next = bnrem_pkg::ST_DONE;
                    end else begin
                        ctrl.load  = 1'b1;
                        cnt_next   = CNT_W'(DIGIT_BITS - 1);
                        state_next = bnrem_pkg::ST_RUN;
                    end
                end
            end
            bnrem_pkg::ST_RUN: begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = bnrem_pkg::ST_DONE;
                end
            end
            bnrem_pkg::ST_DONE: begin
                if (!last_reg) begin
                    state_next = bnrem_pkg::ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    // Hand the word over and start the next number clean.
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    ctrl.clear   = 1'b1;
                    err_next     = 1'b0;
                    state_next   = bnrem_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bnrem_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bnrem_pkg::ST_IDLE;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_rem_reg <= err_reg ? '0 : core_rem;
            m_zd_reg  <= err_reg;
        end
    end

    bnrem_core #(
        .DIGIT_BITS   (DIGIT_BITS),
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .digit     (s_digit),
        .divisor   (s_divisor),
        .remainder (core_rem)
    );

    assign m_valid        = m_valid_reg;
    assign m_remainder    = m_rem_reg;
    assign m_zero_divisor = m_zd_reg;

endmodule

@@ rtl/bnrem_checker.sv @@
// Port-level checks for the remainder-by-word block, bound to the top level.
// Depends on bnrem_pkg and bignum_remainder_by_word_top.
module bnrem_checker #(
    parameter int DIGIT_BITS   = bnrem_pkg::DIGIT_BITS_DEF,
    parameter int DIVISOR_BITS = bnrem_pkg::DIVISOR_BITS_DEF
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [DIGIT_BITS-1:0]    s_digit,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [DIVISOR_BITS-1:0]  m_remainder,
    input logic                     m_zero_divisor
);

    // Reset empties the output register.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // An error word always carries a zero remainder.
    a_err_zero: assert property (@(posedge aclk)
        m_valid && m_zero_divisor |-> m_remainder == '0)
        else $error("zero divisor word with nonzero remainder");

    // The block works on one word at a time.
    a_one_at_a_time: assert property (@(posedge aclk)
        aresetn && s_valid && s_ready |=> !s_ready)
        else $error("ready right after an accepted word");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk)
        aresetn && m_valid && !m_ready |=> m_valid && $stable(m_remainder)
            && $stable(m_zero_divisor))
        else $error("stalled result changed");

    // A waiting input word keeps its digit until it is taken.
    a_in_hold: assert property (@(posedge aclk)
        aresetn && s_valid && !s_ready |=> s_valid && $stable(s_digit))
        else $error("waiting input word changed");

endmodule

bind bignum_remainder_by_word_top bnrem_checker #(
    .DIGIT_BITS   (DIGIT_BITS),
    .DIVISOR_BITS (DIVISOR_BITS)
) u_bnrem_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_digit        (s_digit),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_remainder    (m_remainder),
    .m_zero_divisor (m_zero_divisor)
);
